// ===== rtl/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`default_nettype none
package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 16;
  localparam int unsigned WORD_W    = 32;

  localparam logic [WORD_W-1:0] WORD_ALL_ONES = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_RESP = 2'b10
  } fsm_t;

endpackage
`default_nettype wire

// ===== rtl/deq_ram.sv =====
// Word store of the queue ring: one write port, one registered read port.
`default_nettype none
module deq_ram #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [deq_pkg::WORD_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [ADDR_W-1:0]          raddr,
  output logic      [deq_pkg::WORD_W-1:0] rdata
);
  import deq_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: pointer and count control around the word store.
// After a start, the FSM enters the response state; out_valid is registered from it.
// A new operation is taken only when idle; busy is high in the response state, in which
// the store's registered read returns the new front or back word after a pop.
// The receiver cannot stall: each result is shown for one cycle with out_valid.
// Reset (synchronous, active low) empties the queue; the store itself is not cleared.
`default_nettype none
module double_ended_queue #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH,
  localparam int unsigned ADDR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_kind,
  input  wire logic [deq_pkg::WORD_W-1:0] in_data_value,
  output logic                            out_valid,
  output logic      [deq_pkg::WORD_W-1:0] out_popped_value,
  output logic      [1:0]                 out_status,
  output logic      [CNT_W-1:0]           out_entry_count,
  output logic      [deq_pkg::WORD_W-1:0] out_front_value,
  output logic      [deq_pkg::WORD_W-1:0] out_back_value,
  output logic                            out_is_empty
);
  import deq_pkg::*;

  localparam int unsigned SUM_W = CNT_W + 1;

  fsm_t              state_r, state_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] front_r, front_nxt;
  logic [WORD_W-1:0] back_r, back_nxt;
  logic              fix_front_r, fix_front_nxt;
  logic              fix_back_r, fix_back_nxt;
  logic [WORD_W-1:0] popped_r, popped_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_popped_r, out_front_r, out_back_r;
  status_t           out_status_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_empty_r;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              accept, full, empty;
  kind_t             kind;
  logic [ADDR_W-1:0] tail_pos, new_back_pos, head_inc, head_dec;

  // ring position of head plus offset, offset at most DEPTH
  function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign busy   = (state_r != FSM_IDLE);
  assign accept = start && !busy;
  assign kind   = kind_t'(in_kind);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign tail_pos     = ring_pos(head_r, count_r);
  assign new_back_pos = (count_r >= CNT_W'(2)) ? ring_pos(head_r, count_r - CNT_W'(2))
                                               : head_r;
  assign head_inc     = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
  assign head_dec     = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - ADDR_W'(1);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    fix_front_nxt = fix_front_r;
    fix_back_nxt  = fix_back_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    ram_we        = 1'b0;
    ram_waddr     = tail_pos;
    ram_re        = 1'b0;
    ram_raddr     = head_inc;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          state_nxt     = FSM_RESP;
          fix_front_nxt = 1'b0;
          fix_back_nxt  = 1'b0;
          popped_nxt    = WORD_ALL_ONES;
          status_nxt    = STAT_OK;
          case (kind)
            KIND_PUSH_FRONT: begin
              if (full) begin
                status_nxt = STAT_OVER;
              end else begin
                head_nxt  = head_dec;
                count_nxt = count_r + CNT_W'(1);
                ram_we    = 1'b1;
                ram_waddr = head_dec;
                front_nxt = in_data_value;
                if (empty) begin
                  back_nxt = in_data_value;
                end
              end
            end
            KIND_PUSH_BACK: begin
              if (full) begin
                status_nxt = STAT_OVER;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                ram_we    = 1'b1;
                ram_waddr = tail_pos;
                back_nxt  = in_data_value;
                if (empty) begin
                  front_nxt = in_data_value;
                end
              end
            end
            KIND_POP_FRONT: begin
              if (empty) begin
                status_nxt = STAT_UNDER;
              end else begin
                popped_nxt    = front_r;
                head_nxt      = head_inc;
                count_nxt     = count_r - CNT_W'(1);
                // fetch the word that becomes the new front
                ram_re        = 1'b1;
                ram_raddr     = head_inc;
                fix_front_nxt = 1'b1;
              end
            end
            default: begin
              if (empty) begin
                status_nxt = STAT_UNDER;
              end else begin
                popped_nxt   = back_r;
                count_nxt    = count_r - CNT_W'(1);
                ram_re       = 1'b1;
                ram_raddr    = new_back_pos;
                fix_back_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      FSM_RESP: begin
        state_nxt = FSM_IDLE;
        if (fix_front_r) begin
          front_nxt = ram_rdata;
        end
        if (fix_back_r) begin
          back_nxt = ram_rdata;
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == FSM_RESP);
    end
  end

  always_ff @(posedge clk) begin
    front_r     <= front_nxt;
    back_r      <= back_nxt;
    fix_front_r <= fix_front_nxt;
    fix_back_r  <= fix_back_nxt;
    popped_r    <= popped_nxt;
    status_r    <= status_nxt;
    if (state_r == FSM_RESP) begin
      out_popped_r <= popped_r;
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_empty_r  <= (count_r == '0);
      out_front_r  <= (count_r == '0) ? WORD_ALL_ONES : front_nxt;
      out_back_r   <= (count_r == '0) ? WORD_ALL_ONES : back_nxt;
    end
  end

  deq_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_count_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_is_empty     = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("word count exceeds depth");

  a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == FSM_RESP))
    else $error("accepted word did not enter response cycle");

  a_resp_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_RESP) |=> out_valid_r)
    else $error("response cycle without result strobe");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not advance count");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

endmodule
`default_nettype wire
